>>> rtl/awpa_pkg.sv
`default_nettype none
package awpa_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int TS_W      = 32;
  localparam int FADE_W    = 16;
  localparam int DIM_W     = 9;
  localparam int POS_W     = 8;
  localparam int CH_W      = 3;
  localparam int ACT_W     = 2;
  localparam int COL_W     = 8;
  localparam int PIX_W     = 3 * COL_W;
  localparam int LIN_W     = 2 * DIM_W;
  localparam int PROD_W    = TS_W + FADE_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int DIV_STEPS = TS_W;

  localparam logic [COL_W-1:0] WEIGHT_BASE = 8'd128;
  localparam logic [COL_W-1:0] WEIGHT_FULL = 8'd255;

  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POINT = 2'd1;

  localparam logic [CH_W-1:0] CH_RED   = 3'd1;
  localparam logic [CH_W-1:0] CH_GREEN = 3'd2;
  localparam logic [CH_W-1:0] CH_BLUE  = 3'd3;
  localparam logic [CH_W-1:0] CH_RG    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_END_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd4;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_NOT_OLDER = 3'd1,
    ST_STOPPED   = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_READ      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_CLR,
    S_DIV,
    S_MUL,
    S_CHK,
    S_LOC,
    S_CMP,
    S_RD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic    load;
    logic    eval_point;
    logic    clr_init;
    logic    clr_wr;
    logic    div_start;
    logic    div_step;
    logic    mul_en;
    logic    w_full;
    logic    w_prod;
    logic    set_stop;
    logic    loc_en;
    logic    rd_en;
    logic    mod_en;
    logic    status_ld;
    status_t status;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             stopped;
    logic             older;
    logic             gran_zero;
    logic             div_last;
    logic             neg;
    logic             in_frame;
    logic             clr_last;
    logic             out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/awpa_div.sv
`default_nettype none
module awpa_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic                      step,
  input  wire logic [awpa_pkg::TS_W-1:0] dividend,
  input  wire logic [awpa_pkg::TS_W-1:0] divisor,
  output logic      [awpa_pkg::TS_W-1:0] quotient,
  output logic                           last
);
  import awpa_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [TS_W-1:0]  quo_r, quo_nxt;
  logic [TS_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TS_W:0]    trial;

  // restoring division, one quotient bit per step
  always_comb begin
    trial   = {rem_r, quo_r[TS_W-1]};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (step) begin
      cnt_nxt = cnt_r + 1'b1;
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = TS_W'(trial - {1'b0, divisor});
        quo_nxt = {quo_r[TS_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[TS_W-1:0];
        quo_nxt = {quo_r[TS_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = quo_r;
  assign last     = (cnt_r == CNT_W'(DIV_STEPS - 1));

endmodule
`default_nettype wire

>>> rtl/awpa_dp.sv
`default_nettype none
module awpa_dp #(
  parameter int DEPTH = awpa_pkg::MAX_WIDTH_DEF * awpa_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire awpa_pkg::cmd_t                 cmd,
  output awpa_pkg::sts_t                      sts,
  input  wire logic [awpa_pkg::ACT_W-1:0]     in_action,
  input  wire logic [awpa_pkg::TS_W-1:0]      in_timestamp,
  input  wire logic [awpa_pkg::POS_W-1:0]     in_pos_x,
  input  wire logic [awpa_pkg::POS_W-1:0]     in_pos_y,
  input  wire logic [awpa_pkg::CH_W-1:0]      in_channel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [2:0]                     out_status,
  output logic      [awpa_pkg::COL_W-1:0]     out_red,
  output logic      [awpa_pkg::COL_W-1:0]     out_green,
  output logic      [awpa_pkg::COL_W-1:0]     out_blue,
  output logic      [awpa_pkg::COL_W-1:0]     out_weight,
  input  wire logic                           cfg_we,
  input  wire logic [awpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [awpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import awpa_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] a,
                                               input logic [COL_W-1:0] w);
    logic [COL_W:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[COL_W] ? {COL_W{1'b1}} : s[COL_W-1:0];
  endfunction

  // configuration
  logic [TS_W-1:0]   end_time_r;
  logic [TS_W-1:0]   gran_r;
  logic [FADE_W-1:0] fade_r;
  logic [DIM_W-1:0]  fw_r;
  logic [DIM_W-1:0]  fh_r;

  // item and pass state
  logic [ACT_W-1:0] act_r;
  logic [TS_W-1:0]  ts_r;
  logic [POS_W-1:0] x_r, y_r;
  logic [CH_W-1:0]  ch_r;
  logic [TS_W-1:0]  pass_end_r;
  logic             known_r;
  logic             stop_r;

  logic [TS_W-1:0]   end_val;
  logic              end_all_ones;
  logic [TS_W-1:0]   quotient;
  logic [PROD_W-1:0] prod_r;
  logic [COL_W-1:0]  w_r;
  logic [LIN_W-1:0]  lin_r, lim_r;
  logic [AW+LIN_W-1:0] lin_ext;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     clr_cnt_r;

  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_r;
  logic [PIX_W-1:0]  new_pix;
  logic              used;
  logic              wr_en;
  logic [COL_W-1:0]  pr, pg, pb;

  status_t           res_st_r;
  logic [PIX_W-1:0]  res_pix_r;
  logic [COL_W-1:0]  res_w_r;
  logic              out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_time_r <= '1;
      gran_r     <= '0;
      fade_r     <= FADE_W'(1);
      fw_r       <= DIM_W'(256);
      fh_r       <= DIM_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_END_TIME:     end_time_r <= cfg_wdata;
        CFG_GRANULARITY:  gran_r     <= cfg_wdata;
        CFG_FADE_RATE:    fade_r     <= cfg_wdata[FADE_W-1:0];
        CFG_FRAME_WIDTH:  fw_r       <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: fh_r       <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      ts_r  <= in_timestamp;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      ch_r  <= in_channel;
    end
  end

  assign end_all_ones = (end_time_r == '1);
  assign end_val = end_all_ones ? (known_r ? pass_end_r : ts_r) : end_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_end_r <= '0;
      known_r    <= 1'b0;
      stop_r     <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        known_r <= 1'b0;
        stop_r  <= 1'b0;
      end
      if (cmd.eval_point && end_all_ones && !known_r) begin
        pass_end_r <= ts_r;
        known_r    <= 1'b1;
      end
      if (cmd.set_stop) begin
        stop_r <= 1'b1;
      end
    end
  end

  awpa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (end_val - ts_r),
    .divisor  (gran_r),
    .quotient (quotient),
    .last     (sts.div_last)
  );

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= {{FADE_W{1'b0}}, quotient} * {{TS_W{1'b0}}, fade_r};
    end
    if (cmd.w_full) begin
      w_r <= WEIGHT_FULL;
    end else if (cmd.w_prod) begin
      // product is at most the base here, so the low byte is exact
      w_r <= WEIGHT_BASE - prod_r[COL_W-1:0];
    end
    if (cmd.loc_en) begin
      lin_r <= LIN_W'(x_r) + LIN_W'(y_r) * LIN_W'(fw_r);
      lim_r <= LIN_W'(fw_r) * LIN_W'(fh_r);
    end
  end

  assign lin_ext = (AW + LIN_W)'(lin_r);
  assign addr    = lin_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_init) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // read-modify-write of one pixel
  assign {pr, pg, pb} = rdata_r;

  always_comb begin
    new_pix = rdata_r;
    used    = 1'b0;
    if (act_r == ACT_POINT) begin
      used = 1'b1;
      unique case (ch_r)
        CH_RED:   new_pix = {sat_add(pr, w_r), pg, pb};
        CH_GREEN: new_pix = {pr, sat_add(pg, w_r), pb};
        CH_BLUE:  new_pix = {pr, pg, sat_add(pb, w_r)};
        CH_RG:    new_pix = {sat_add(pr, w_r), sat_add(pg, w_r), pb};
        default:  used = 1'b0;
      endcase
    end
  end

  assign wr_en = cmd.mod_en && (act_r == ACT_POINT);

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[addr] <= new_pix;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.status_ld) begin
      res_st_r <= cmd.status;
    end
    if (cmd.mod_en) begin
      res_pix_r <= new_pix;
      res_w_r   <= used ? w_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status <= res_st_r;
      if (res_st_r == ST_ADDED || res_st_r == ST_READ) begin
        {out_red, out_green, out_blue} <= res_pix_r;
      end else begin
        {out_red, out_green, out_blue} <= '0;
      end
      out_weight <= (res_st_r == ST_ADDED) ? res_w_r : '0;
    end
  end

  assign out_valid = out_valid_r;

  assign sts.action    = act_r;
  assign sts.stopped   = stop_r;
  assign sts.older     = (ts_r < end_val);
  assign sts.gran_zero = (gran_r == '0);
  assign sts.neg       = (prod_r > PROD_W'(WEIGHT_BASE));
  assign sts.in_frame  = (lin_r < lim_r) && (32'(lin_r) < 32'(DEPTH));
  assign sts.clr_last  = (clr_cnt_r == AW'(DEPTH - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

>>> rtl/awpa_ctrl.sv
`default_nettype none
module awpa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire awpa_pkg::sts_t sts,
  output awpa_pkg::cmd_t      cmd
);
  import awpa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: begin
        priority case (sts.action)
          ACT_CLEAR: state_nxt = S_CLR;
          ACT_POINT: begin
            priority if (sts.stopped || !sts.older) state_nxt = S_FIN;
            else if (sts.gran_zero) state_nxt = S_LOC;
            else state_nxt = S_DIV;
          end
          default: state_nxt = S_LOC;
        endcase
      end
      S_CLR: if (sts.clr_last) state_nxt = S_FIN;
      S_DIV: if (sts.div_last) state_nxt = S_MUL;
      S_MUL: state_nxt = S_CHK;
      S_CHK: state_nxt = sts.neg ? S_FIN : S_LOC;
      S_LOC: state_nxt = S_CMP;
      S_CMP: state_nxt = sts.in_frame ? S_RD : S_FIN;
      S_RD:  state_nxt = S_FIN;
      S_FIN: if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = ST_ADDED;
    unique case (state_r)
      S_INIT: cmd.clr_wr = 1'b1;
      S_IDLE: cmd.load = in_valid;
      S_EVAL: begin
        priority case (sts.action)
          ACT_CLEAR: begin
            cmd.clr_init  = 1'b1;
            cmd.status_ld = 1'b1;
            cmd.status    = ST_CLEARED;
          end
          ACT_POINT: begin
            cmd.eval_point = 1'b1;
            priority if (sts.stopped) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_STOPPED;
            end else if (!sts.older) begin
              cmd.status_ld = 1'b1;
              cmd.status    = ST_NOT_OLDER;
            end else if (sts.gran_zero) begin
              cmd.w_full = 1'b1;
            end else begin
              cmd.div_start = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_CLR: cmd.clr_wr   = 1'b1;
      S_DIV: cmd.div_step = 1'b1;
      S_MUL: cmd.mul_en   = 1'b1;
      S_CHK: begin
        if (sts.neg) begin
          cmd.set_stop  = 1'b1;
          cmd.status_ld = 1'b1;
          cmd.status    = ST_STOPPED;
        end else begin
          cmd.w_prod = 1'b1;
        end
      end
      S_LOC: cmd.loc_en = 1'b1;
      S_CMP: begin
        if (sts.in_frame) begin
          cmd.rd_en = 1'b1;
        end else begin
          cmd.status_ld = 1'b1;
          cmd.status    = ST_OUTSIDE;
        end
      end
      S_RD: begin
        cmd.mod_en    = 1'b1;
        cmd.status_ld = 1'b1;
        cmd.status    = (sts.action == ACT_POINT) ? ST_ADDED : ST_READ;
      end
      S_FIN: cmd.out_ld = sts.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/age_weighted_point_accumulator_core.sv
// Age-weighted point accumulator over an RGB frame store.
// Input channel (in_valid / in_stall) takes one word per item: clear, point or read.
// Result channel (out_valid / out_stall) gives exactly one word per item.
// Configuration is written via cfg_we / cfg_index / cfg_wdata by the user while idle; not enforced.
// Items are handled one at a time; in_stall is low only when the block is idle.
// A point with granularity nonzero passes from accept through evaluation, the divider
//   steps, multiply, check, address, bounds compare, pixel read-modify-write and
//   result load. A point with granularity zero and a read skip divider, multiply
//   and check; a point rejected early goes from evaluation straight to result load.
// The next word can be taken in the cycle after the result loads.
// Clear: the one-pixel-per-cycle zeroing sweep over the store's single write port.
// After reset the same sweep runs with in_stall high;
//   configuration writes are taken meanwhile.
// The result sits in an output register; while out_stall is high it holds,
//   and the next item may be accepted and worked on, waiting only to load its result.
`default_nettype none
module age_weighted_point_accumulator_core #(
  parameter int MAX_WIDTH  = awpa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = awpa_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [awpa_pkg::ACT_W-1:0]     in_action,
  input  wire logic [awpa_pkg::TS_W-1:0]      in_timestamp,
  input  wire logic [awpa_pkg::POS_W-1:0]     in_pos_x,
  input  wire logic [awpa_pkg::POS_W-1:0]     in_pos_y,
  input  wire logic [awpa_pkg::CH_W-1:0]      in_channel,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [2:0]                     out_status,
  output logic      [awpa_pkg::COL_W-1:0]     out_red,
  output logic      [awpa_pkg::COL_W-1:0]     out_green,
  output logic      [awpa_pkg::COL_W-1:0]     out_blue,
  output logic      [awpa_pkg::COL_W-1:0]     out_weight,
  input  wire logic                           cfg_we,
  input  wire logic [awpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [awpa_pkg::CFG_W-1:0]     cfg_wdata
);
  import awpa_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  cmd_t cmd;
  sts_t sts;

  awpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  awpa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_action),
    .in_timestamp (in_timestamp),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_channel   (in_channel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_weight   (out_weight),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

endmodule
`default_nettype wire

>>> rtl/awpa_chk.sv
`default_nettype none
module awpa_chk (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [2:0]                 out_status,
  input wire logic [awpa_pkg::COL_W-1:0] out_red,
  input wire logic [awpa_pkg::COL_W-1:0] out_green,
  input wire logic [awpa_pkg::COL_W-1:0] out_blue,
  input wire logic [awpa_pkg::COL_W-1:0] out_weight
);
  import awpa_pkg::*;

  // reset leaves the block busy with its store sweep and no word pending
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("busy/empty state not entered after reset");

  // one item at a time: an accepted word makes the input busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_weight))
    else $error("stalled result changed");

  a_weight_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ADDED |-> out_weight == '0)
    else $error("weight on a result that added nothing");

  a_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_ADDED && out_status != ST_READ
      |-> out_red == '0 && out_green == '0 && out_blue == '0)
    else $error("pixel on a result without pixel");

endmodule

bind age_weighted_point_accumulator_core awpa_chk u_awpa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .out_weight (out_weight)
);
`default_nettype wire

>>> verif/frame_result_checker.sv
module frame_result_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [awpa_pkg::ACT_W-1:0]     in_action,
  input  logic [awpa_pkg::TS_W-1:0]      in_timestamp,
  input  logic [awpa_pkg::POS_W-1:0]     in_pos_x,
  input  logic [awpa_pkg::POS_W-1:0]     in_pos_y,
  input  logic [awpa_pkg::CH_W-1:0]      in_channel,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [2:0]                     out_status,
  input  logic [awpa_pkg::COL_W-1:0]     out_red,
  input  logic [awpa_pkg::COL_W-1:0]     out_green,
  input  logic [awpa_pkg::COL_W-1:0]     out_blue,
  input  logic [awpa_pkg::COL_W-1:0]     out_weight,
  input  logic                           cfg_we,
  input  logic [awpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [awpa_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import awpa_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

  typedef struct packed {
    status_t          status;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic [COL_W-1:0] weight;
  } pix_result_t;

  logic [TS_W-1:0]   reg_end;
  logic [TS_W-1:0]   reg_gran;
  logic [FADE_W-1:0] reg_fade;
  logic [DIM_W-1:0]  reg_fw;
  logic [DIM_W-1:0]  reg_fh;

  // pixel packed as {red, green, blue}; missing entries read as zero
  logic [PIX_W-1:0] pix_mem [int];
  logic [TS_W-1:0]  latched_end;
  bit               end_latched;
  bit               pass_stopped;
  pix_result_t      pixels_due [$];

  function automatic logic [COL_W-1:0] sat_add(input logic [COL_W-1:0] a,
                                               input logic [COL_W-1:0] w);
    logic [COL_W:0] s;
    s = {1'b0, a} + {1'b0, w};
    return s[COL_W] ? WEIGHT_FULL : s[COL_W-1:0];
  endfunction

  function automatic bit locate_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                      output int lin);
    logic [31:0] l;
    logic [31:0] lim;
    l   = 32'(x) + 32'(y) * 32'(reg_fw);
    lim = 32'(reg_fw) * 32'(reg_fh);
    lin = int'(l);
    return (l < lim) && (l < STORE_DEPTH);
  endfunction

  function automatic pix_result_t apply_item(input logic [ACT_W-1:0] act,
                                             input logic [TS_W-1:0] ts,
                                             input logic [POS_W-1:0] x,
                                             input logic [POS_W-1:0] y,
                                             input logic [CH_W-1:0] ch);
    pix_result_t      r;
    logic [TS_W-1:0]  end_t;
    logic [TS_W-1:0]  q;
    logic [63:0]      prod;
    logic [COL_W-1:0] w;
    logic [PIX_W-1:0] pix;
    int               lin;
    r = '0;
    if (act == ACT_CLEAR) begin
      pix_mem.delete();
      end_latched  = 1'b0;
      pass_stopped = 1'b0;
      r.status = ST_CLEARED;
    end else if (act == ACT_POINT) begin
      // all-ones register: end time comes from the first point of the pass
      if (reg_end == '1) begin
        if (!end_latched) begin
          latched_end = ts;
          end_latched = 1'b1;
        end
        end_t = latched_end;
      end else begin
        end_t = reg_end;
      end
      if (pass_stopped) begin
        r.status = ST_STOPPED;
      end else if (!(ts < end_t)) begin
        r.status = ST_NOT_OLDER;
      end else begin
        w    = WEIGHT_FULL;
        prod = '0;
        if (reg_gran != 0) begin
          q    = (end_t - ts) / reg_gran;
          prod = 64'(q) * 64'(reg_fade);
          w    = WEIGHT_BASE - prod[COL_W-1:0];
        end
        if (prod > 64'(WEIGHT_BASE)) begin
          pass_stopped = 1'b1;
          r.status = ST_STOPPED;
        end else if (!locate_pixel(x, y, lin)) begin
          r.status = ST_OUTSIDE;
        end else begin
          pix = pix_mem.exists(lin) ? pix_mem[lin] : '0;
          r.weight = w;
          case (ch)
            CH_RED:   pix[23:16] = sat_add(pix[23:16], w);
            CH_GREEN: pix[15:8]  = sat_add(pix[15:8], w);
            CH_BLUE:  pix[7:0]   = sat_add(pix[7:0], w);
            CH_RG: begin
              pix[23:16] = sat_add(pix[23:16], w);
              pix[15:8]  = sat_add(pix[15:8], w);
            end
            default:  r.weight = '0;
          endcase
          pix_mem[lin] = pix;
          r.status = ST_ADDED;
          {r.red, r.green, r.blue} = pix;
        end
      end
    end else begin
      // read, and the spare action code acts as a read
      if (locate_pixel(x, y, lin)) begin
        r.status = ST_READ;
        {r.red, r.green, r.blue} = pix_mem.exists(lin) ? pix_mem[lin] : '0;
      end else begin
        r.status = ST_OUTSIDE;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pix_result_t exp_r;
    if (!rst_n) begin
      reg_end      = '1;
      reg_gran     = '0;
      reg_fade     = 16'd1;
      reg_fw       = 9'd256;
      reg_fh       = 9'd256;
      pix_mem.delete();
      latched_end  = '0;
      end_latched  = 1'b0;
      pass_stopped = 1'b0;
      pixels_due.delete();
      fail_count   = 0;
      compared     = 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_TIME:     reg_end  = cfg_wdata[TS_W-1:0];
          CFG_GRANULARITY:  reg_gran = cfg_wdata[TS_W-1:0];
          CFG_FADE_RATE:    reg_fade = cfg_wdata[FADE_W-1:0];
          CFG_FRAME_WIDTH:  reg_fw   = cfg_wdata[DIM_W-1:0];
          CFG_FRAME_HEIGHT: reg_fh   = cfg_wdata[DIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 50)
            $display("%0t: unexpected result word: status %0d rgb %h/%h/%h weight %0d",
                     $time, out_status, out_red, out_green, out_blue, out_weight);
        end else begin
          exp_r = pixels_due.pop_front();
          compared++;
          if (out_status !== exp_r.status || out_red !== exp_r.red ||
              out_green !== exp_r.green || out_blue !== exp_r.blue ||
              out_weight !== exp_r.weight) begin
            fail_count++;
            if (fail_count <= 50) begin
              $display("%0t: mismatch: expected status %0d rgb %h/%h/%h weight %0d,",
                       $time, exp_r.status, exp_r.red, exp_r.green, exp_r.blue,
                       exp_r.weight);
              $display("%0t:   got status %0d rgb %h/%h/%h weight %0d",
                       $time, out_status, out_red, out_green, out_blue, out_weight);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pixels_due.push_back(apply_item(in_action, in_timestamp, in_pos_x, in_pos_y,
                                        in_channel));
      pending <= pixels_due.size();
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import awpa_pkg::*;

  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [CH_W-1:0]  CH_NONE   = 3'd0;
  localparam logic [CH_W-1:0]  CH_SPARE  = 3'd7;

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action    = '0;
  logic [TS_W-1:0]      in_timestamp = '0;
  logic [POS_W-1:0]     in_pos_x     = '0;
  logic [POS_W-1:0]     in_pos_y     = '0;
  logic [CH_W-1:0]      in_channel   = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [2:0]           out_status;
  logic [COL_W-1:0]     out_red;
  logic [COL_W-1:0]     out_green;
  logic [COL_W-1:0]     out_blue;
  logic [COL_W-1:0]     out_weight;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_wdata    = '0;

  int fail_count;
  int pending;
  int compared;
  int words_sent     = 0;
  int settings_used  = 0;
  int burst_left     = 0;
  int stall_left     = 0;
  int stall_mode     = 0;

  // current register values, used to shape the passes
  logic [TS_W-1:0]   gran_q;
  logic [FADE_W-1:0] fade_q;
  logic [DIM_W-1:0]  fw_q;
  logic [DIM_W-1:0]  fh_q;

  age_weighted_point_accumulator_core uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_timestamp, .in_pos_x, .in_pos_y, .in_channel,
    .out_valid, .out_stall, .out_status, .out_red, .out_green, .out_blue, .out_weight,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  frame_result_checker result_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_action, .in_timestamp, .in_pos_x, .in_pos_y, .in_channel,
    .out_valid, .out_stall, .out_status, .out_red, .out_green, .out_blue, .out_weight,
    .cfg_we, .cfg_index, .cfg_wdata,
    .fail_count, .pending, .compared
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver: windows of free flow, light stall, heavy stall or a solid hold
  always @(posedge clk) begin : stall_gen
    int m;
    if (stall_left == 0) begin
      m = $urandom_range(3, 0);
      stall_mode <= m;
      stall_left <= (m == 3) ? $urandom_range(40, 1) : $urandom_range(200, 1);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(2, 0) == 0);
        2:       out_stall <= ($urandom_range(3, 0) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  task automatic send_word(input logic [ACT_W-1:0] act, input logic [TS_W-1:0] ts,
                           input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                           input logic [CH_W-1:0] ch);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(40, 1);
      in_valid <= 1'b0;
      repeat ($urandom_range(30, 1)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_timestamp <= ts;
    in_pos_x     <= x;
    in_pos_y     <= y;
    in_channel   <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // hold off until every result word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input logic [TS_W-1:0] e, input logic [TS_W-1:0] g,
                          input logic [FADE_W-1:0] f, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_END_TIME;
    cfg_wdata <= e;
    @(posedge clk);
    cfg_index <= CFG_GRANULARITY;
    cfg_wdata <= g;
    @(posedge clk);
    // junk above the register width must be ignored
    cfg_index <= CFG_FADE_RATE;
    cfg_wdata <= {16'($urandom()), f};
    @(posedge clk);
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_wdata <= {23'($urandom()), w};
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_wdata <= {23'($urandom()), h};
    @(posedge clk);
    cfg_we <= 1'b0;
    gran_q = g;
    fade_q = f;
    fw_q   = w;
    fh_q   = h;
    settings_used++;
  endtask

  // a few hot pixels for saturation, else inside the frame, else anywhere
  function automatic void pick_pos(output logic [POS_W-1:0] x, output logic [POS_W-1:0] y);
    int sel;
    int xmax;
    int ymax;
    sel  = $urandom_range(2, 0);
    xmax = (fw_q > 9'd256) ? 255 : int'(fw_q) - 1;
    ymax = (fh_q > 9'd256) ? 255 : int'(fh_q) - 1;
    if (sel == 0) begin
      x = 8'($urandom_range(3, 0));
      y = 8'($urandom_range(1, 0));
    end else if (sel == 1 && xmax >= 0 && ymax >= 0) begin
      x = 8'($urandom_range(xmax, 0));
      y = 8'($urandom_range(ymax, 0));
    end else begin
      x = 8'($urandom());
      y = 8'($urandom());
    end
  endfunction

  // one pass: clear, then points newest first with reads and noise mixed in
  task automatic run_pass(input logic [TS_W-1:0] ts_start, input int n_words);
    logic [TS_W-1:0]  ts;
    logic [TS_W-1:0]  step;
    logic [TS_W-1:0]  step_max;
    logic [63:0]      span;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [CH_W-1:0]  ch;
    int               roll;
    ts = ts_start;
    if (gran_q == 0 || fade_q == 0) begin
      step_max = 32'd1 << $urandom_range(20, 4);
    end else begin
      // aim for the weight to run out somewhere near the end of the pass
      span = 64'(gran_q) * (64'(WEIGHT_BASE) / 64'(fade_q) + 64'd1) / 64'd45 + 64'd1;
      step_max = (span > 64'hffff_ffff) ? '1 : span[TS_W-1:0];
    end
    send_word(ACT_CLEAR, $urandom(), 8'($urandom()), 8'($urandom()), 3'($urandom()));
    repeat (n_words) begin
      roll = $urandom_range(99, 0);
      pick_pos(x, y);
      ch = ($urandom_range(9, 0) == 0) ? 3'($urandom()) : 3'($urandom_range(4, 1));
      if (roll < 70) begin
        step = $urandom_range(step_max, 0);
        ts   = (step > ts) ? '0 : ts - step;
        send_word(ACT_POINT, ts, x, y, ch);
      end else if (roll < 88) begin
        send_word(($urandom_range(7, 0) == 0) ? ACT_SPARE : ACT_READ, $urandom(), x, y, ch);
      end else begin
        send_word(ACT_POINT, $urandom(), 8'($urandom()), 8'($urandom()), 3'($urandom()));
      end
    end
  endtask

  initial begin : stimulus
    logic [TS_W-1:0] ts_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // latched end time, decay, saturation, weight exactly zero, then the stop
    set_regs('1, 32'd10, 16'd1, 9'd256, 9'd256);
    send_word(ACT_READ, 32'd0, 8'd0, 8'd0, CH_NONE);
    send_word(ACT_POINT, 32'd100000, 8'd0, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd100000, 8'd0, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd99999, 8'd0, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd99990, 8'd0, 8'd0, CH_RG);
    send_word(ACT_POINT, 32'd99995, 8'd0, 8'd0, CH_GREEN);
    send_word(ACT_POINT, 32'd99980, 8'd0, 8'd0, CH_NONE);
    send_word(ACT_POINT, 32'd99970, 8'hff, 8'hff, CH_SPARE);
    send_word(ACT_POINT, 32'd99960, 8'hff, 8'hff, CH_BLUE);
    send_word(ACT_SPARE, 32'd0, 8'hff, 8'hff, CH_NONE);
    send_word(ACT_POINT, 32'd98720, 8'd1, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd98710, 8'd1, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd98000, 8'd1, 8'd0, CH_RED);
    send_word(ACT_CLEAR, 32'd0, 8'd0, 8'd0, CH_NONE);

    // zero frame width drops everything
    set_regs('1, 32'd10, 16'd1, 9'd0, 9'd256);
    send_word(ACT_POINT, 32'd100, 8'd3, 8'd3, CH_RED);
    send_word(ACT_POINT, 32'd50, 8'd3, 8'd3, CH_RED);
    send_word(ACT_READ, 32'd0, 8'd0, 8'd0, CH_NONE);

    // one-pixel frame, timestamp extremes, widest divisor
    set_regs(32'hffff_fffe, '1, 16'hffff, 9'd1, 9'd1);
    send_word(ACT_POINT, '1, 8'd0, 8'd0, CH_RED);
    send_word(ACT_POINT, 32'd0, 8'd0, 8'd0, CH_RG);
    send_word(ACT_POINT, 32'd5, 8'd1, 8'd0, CH_BLUE);
    send_word(ACT_READ, 32'd0, 8'd0, 8'd1, CH_NONE);
    send_word(ACT_READ, 32'd0, 8'd0, 8'd0, CH_NONE);

    set_regs(32'd0, 32'd1, 16'hffff, 9'd1, 9'd1);
    send_word(ACT_POINT, 32'd0, 8'd0, 8'd0, CH_RED);
    // huge product from the fastest fade
    set_regs(32'hffff_fffe, 32'd1, 16'hffff, 9'd256, 9'd256);
    send_word(ACT_POINT, 32'hffff_fffd, 8'd0, 8'd0, CH_RED);

    for (int ph = 0; ph < 7; ph++) begin
      ts_start = $urandom();
      case (ph)
        0: set_regs('1, 32'd0, 16'd1, 9'd256, 9'd256);
        1: set_regs('1, $urandom_range(5000, 1), 16'($urandom_range(4, 1)),
                    9'($urandom_range(256, 1)), 9'($urandom_range(256, 1)));
        2: set_regs(ts_start + $urandom_range(2000, 0), $urandom_range(100000, 1), 16'd0,
                    9'd256, 9'($urandom_range(256, 1)));
        3: set_regs('1, '1, 16'hffff, 9'd300, 9'd200);
        4: set_regs('1, $urandom_range(64, 1), 16'($urandom_range(16, 1)), 9'd16, 9'd16);
        5: set_regs(ts_start + $urandom_range(2000, 0), $urandom(),
                    16'($urandom_range(255, 1)), 9'd256, 9'd1);
        default: set_regs('1, $urandom_range(100000, 1), 16'($urandom_range(3, 1)),
                          9'd1, 9'd256);
      endcase
      run_pass(ts_start, 150);
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d words under %0d register settings, %0d result words compared",
             words_sent, settings_used, compared);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/awpa_pkg.sv
rtl/awpa_div.sv
rtl/awpa_dp.sv
rtl/awpa_ctrl.sv
rtl/age_weighted_point_accumulator_core.sv
rtl/awpa_chk.sv
verif/frame_result_checker.sv
verif/tb.sv
